// ===== hdl/ndl_pkg.sv =====
`timescale 1ns / 1ps
// ndl_pkg: shared widths, status codes, divider control type and the fixed
// thermistor table for the ntc divider temperature block. No dependencies.

package ndl_pkg;

    // fixed table size and field widths
    localparam int BASE_ENTRIES = 39;
    localparam int RES_W        = 26;
    localparam int TEMP_W       = 16;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // shared divider widths: full pass and short pass for interpolation
    localparam int DIVD_W  = 44;
    localparam int DIVS_W  = 26;
    localparam int SHORT_W = 16;
    localparam int CNT_W   = 6;

    // range status codes
    localparam logic [1:0] STATUS_VALID = 2'd0;
    localparam logic [1:0] STATUS_ABOVE = 2'd1;
    localparam logic [1:0] STATUS_BELOW = 2'd2;

    // sentinels for out-of-range voltages
    localparam logic signed [TEMP_W-1:0] TEMP_LOW_SENT  = 16'sh8000;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH_SENT = 16'sh7FFF;

    // configuration register indexes
    localparam logic [1:0] REG_SUPPLY  = 2'd0;
    localparam logic [1:0] REG_DIVIDER = 2'd1;
    localparam logic [1:0] REG_UPPER   = 2'd2;

    // divider launch control
    typedef struct packed {
        logic start;
        logic short_mode;
    } div_ctrl_t;

    // thermistor resistance, 18.8 fixed point ohms; entries past the end repeat the last
    function automatic logic [RES_W-1:0] ntc_res(input logic [7:0] k);
        logic [RES_W-1:0] r;
        case (k)
            8'd0:    r = 26'd48647680;
            8'd1:    r = 26'd37212160;
            8'd2:    r = 26'd28687360;
            8'd3:    r = 26'd22282496;
            8'd4:    r = 26'd17434624;
            8'd5:    r = 26'd13738240;
            8'd6:    r = 26'd10899456;
            8'd7:    r = 26'd8704256;
            8'd8:    r = 26'd6995456;
            8'd9:    r = 26'd5656576;
            8'd10:   r = 26'd4601088;
            8'd11:   r = 26'd3763968;
            8'd12:   r = 26'd3095808;
            8'd13:   r = 26'd2560000;
            8'd14:   r = 26'd2127693;
            8'd15:   r = 26'd1777101;
            8'd16:   r = 26'd1491328;
            8'd17:   r = 26'd1257267;
            8'd18:   r = 26'd1064627;
            8'd19:   r = 26'd905344;
            8'd20:   r = 26'd773043;
            8'd21:   r = 26'd662733;
            8'd22:   r = 26'd570317;
            8'd23:   r = 26'd492621;
            8'd24:   r = 26'd427034;
            8'd25:   r = 26'd371456;
            8'd26:   r = 26'd324173;
            8'd27:   r = 26'd283853;
            8'd28:   r = 26'd249295;
            8'd29:   r = 26'd219617;
            8'd30:   r = 26'd194035;
            8'd31:   r = 26'd171917;
            8'd32:   r = 26'd152737;
            8'd33:   r = 26'd136054;
            8'd34:   r = 26'd121505;
            8'd35:   r = 26'd108782;
            8'd36:   r = 26'd97623;
            8'd37:   r = 26'd87813;
            default: r = 26'd79168;
        endcase
        return r;
    endfunction

    // table temperature in 0.1 degC: -40.0 degC in 5 degC steps, last entry repeats
    function automatic logic signed [TEMP_W-1:0] ntc_temp(input logic [7:0] k);
        logic signed [TEMP_W-1:0] t;
        if (k < 8'(BASE_ENTRIES)) begin
            t = 16'(-400 + 50 * int'(k));
        end else begin
            t = 16'sd1500;
        end
        return t;
    endfunction

endpackage

// ===== hdl/ndl_mul.sv =====
`timescale 1ns / 1ps
// ndl_mul: shared signed multiplier with a registered product.
// Depends on ndl_pkg for operand widths.

module ndl_mul (
    input  logic                                clk,
    input  logic signed [ndl_pkg::MUL_A_W-1:0]  op_a,
    input  logic signed [ndl_pkg::MUL_B_W-1:0]  op_b,
    output logic signed [ndl_pkg::PROD_W-1:0]   prod
);
    import ndl_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // one product per cycle, result registered
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/ndl_div.sv =====
`timescale 1ns / 1ps
// ndl_div: shared restoring divider, one quotient bit per cycle.
// Full pass runs DIVD_W steps, short pass SHORT_W steps. Depends on ndl_pkg.

module ndl_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ndl_pkg::div_ctrl_t            ctrl,
    input  logic [ndl_pkg::DIVD_W-1:0]    dividend,
    input  logic [ndl_pkg::DIVS_W-1:0]    divisor,
    output logic                          done,
    output logic [ndl_pkg::DIVD_W-1:0]    quotient
);
    import ndl_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] divisor_reg;
    logic [DIVD_W-1:0] dq_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              fits;

    // trial subtract of the divisor from the shifted partial remainder
    assign trial = {rem_reg, dq_reg[DIVD_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};
    assign diff  = trial - {1'b0, divisor_reg};

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg  <= 1'b1;
                count_reg <= ctrl.short_mode ? CNT_W'(SHORT_W) : CNT_W'(DIVD_W);
            end else if (busy_reg) begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (ctrl.start) begin
            divisor_reg <= divisor;
            if (ctrl.short_mode) begin
                // quotient known to fit SHORT_W bits: upper part starts as remainder
                rem_reg <= dividend[SHORT_W +: DIVS_W];
                dq_reg  <= {dividend[SHORT_W-1:0], {(DIVD_W-SHORT_W){1'b0}}};
            end else begin
                rem_reg <= '0;
                dq_reg  <= dividend;
            end
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            dq_reg  <= {dq_reg[DIVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ===== hdl/ntc_divider_lut_temperature_core.sv =====
`timescale 1ns / 1ps
// ntc_divider_lut_temperature_core: thermistor divider voltage to temperature.
// Depends on ndl_pkg, ndl_mul and ndl_div.
//
// Usage:
//   Input channel in_valid/in_ready carries adc_mv (mV). One result beat per
//   input beat on out_valid/out_ready: temp_tenths (0.1 degC, signed)
//   and range_status (0 valid, 1 voltage above range, 2 voltage below range).
//   Configuration beats on cfg_valid/cfg_ready write supply_mv (index 0),
//   divider_ohm (index 1) or ntc_is_upper (index 2); cfg_ready is always high.
// Processing order:
//   One item at a time; in_ready is high only while the sequencer is idle, so the
//   next input beat is taken in the cycle after the result is registered at the earliest.
//   Out-of-range voltages: the range check states, then the output state.
//   In-range: the range check states, then the 44-step resistance pass of the shared
//   divider, the binary table search and the 16-step interpolation pass of the shared
//   divider, then the output state.
// Reset and stall:
//   Reset loads supply 3000 mV, divider 10000 ohm, thermistor as lower resistor
//   and empties the output register. While the receiver stalls, a finished
//   result waits in the sequencer until the output register frees up.

module ntc_divider_lut_temperature_core #(
    parameter int TABLE_ENTRIES = 39
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [15:0]                          adc_mv,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ndl_pkg::TEMP_W-1:0]    temp_tenths,
    output logic [1:0]                           range_status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [19:0]                          cfg_data
);
    import ndl_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] SEARCH_HI = IDX_W'(TABLE_ENTRIES - 2);

    // sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_CHK0      = 4'd1;
    localparam logic [3:0] ST_CHK1      = 4'd2;
    localparam logic [3:0] ST_CHK2      = 4'd3;
    localparam logic [3:0] ST_CHK3      = 4'd4;
    localparam logic [3:0] ST_CHK4      = 4'd5;
    localparam logic [3:0] ST_DIV1      = 4'd6;
    localparam logic [3:0] ST_DIV1_WAIT = 4'd7;
    localparam logic [3:0] ST_SEARCH    = 4'd8;
    localparam logic [3:0] ST_INT_M0    = 4'd9;
    localparam logic [3:0] ST_INT_M1    = 4'd10;
    localparam logic [3:0] ST_INT_SUM   = 4'd11;
    localparam logic [3:0] ST_DIV2_WAIT = 4'd12;
    localparam logic [3:0] ST_OUT       = 4'd13;

    logic [3:0]  state_reg, state_next;

    logic [12:0] supply_reg;
    logic [19:0] divider_reg;
    logic        upper_reg;

    logic [15:0]              adc_reg;
    logic signed [PROD_W-1:0] lhs_reg;
    logic                     above_reg;
    logic [RES_W-1:0]         r_reg;
    logic [IDX_W-1:0]         lo_reg;
    logic [IDX_W-1:0]         hi_reg;
    logic                     neg_reg;
    logic signed [TEMP_W-1:0] res_temp_reg;
    logic [1:0]               res_status_reg;

    logic                     out_valid_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic [1:0]               out_status_reg;

    // shared unit connections
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    div_ctrl_t                 div_ctrl;
    logic [DIVD_W-1:0]         div_dividend;
    logic [DIVS_W-1:0]         div_divisor;
    logic                      div_done;
    logic [DIVD_W-1:0]         div_quot;

    // divider operating point
    logic [27:0]        d256;
    logic [RES_W-1:0]   r0;
    logic [RES_W-1:0]   rl;
    logic [28:0]        r0_d;
    logic [28:0]        rl_d;
    logic               s_gt_v;
    logic [15:0]        s_minus_v;
    logic [15:0]        den16;

    // search and interpolation
    logic [IDX_W:0]           mid_sum;
    logic [IDX_W-1:0]         mid;
    logic [IDX_W-1:0]         mid_p1;
    logic                     pred;
    logic signed [TEMP_W-1:0] t0;
    logic signed [TEMP_W-1:0] t1;
    logic signed [TEMP_W:0]   dt;
    logic [RES_W-1:0]         r_sel;
    logic [RES_W-1:0]         r_sel1;
    logic                     dr_pos;
    logic [RES_W-1:0]         dr;
    logic [RES_W-1:0]         off;
    logic signed [PROD_W-1:0] sum;
    logic [PROD_W-1:0]        mag;
    logic                     sum_neg;
    logic [SHORT_W-1:0]       q16;
    logic                     below_now;
    logic                     out_free;

    assign d256      = {divider_reg, 8'd0};
    assign r0        = ntc_res(8'd0);
    assign rl        = ntc_res(8'(LAST_IDX));
    assign r0_d      = 29'(r0) + 29'(d256);
    assign rl_d      = 29'(rl) + 29'(d256);
    assign s_gt_v    = 16'(supply_reg) > adc_reg;
    assign s_minus_v = s_gt_v ? (16'(supply_reg) - adc_reg) : 16'd0;
    assign den16     = upper_reg ? adc_reg : s_minus_v;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[IDX_W:1];
    assign mid_p1  = mid + IDX_W'(1);
    assign pred    = r_reg >= ntc_res(8'(mid_p1));

    assign t0     = ntc_temp(8'(lo_reg));
    assign t1     = ntc_temp(8'(lo_reg + IDX_W'(1)));
    assign dt     = (TEMP_W+1)'(t1) - (TEMP_W+1)'(t0);
    assign r_sel  = ntc_res(8'(lo_reg));
    assign r_sel1 = ntc_res(8'(lo_reg + IDX_W'(1)));
    assign dr_pos = r_sel > r_sel1;
    assign dr     = r_sel - r_sel1;
    assign off    = r_sel - r_reg;

    assign sum     = lhs_reg + prod;
    assign sum_neg = sum[PROD_W-1];
    assign mag     = sum_neg ? PROD_W'(-sum) : PROD_W'(sum);
    assign q16     = div_quot[SHORT_W-1:0];

    assign below_now = lhs_reg < prod;
    assign out_free  = !out_valid_reg || out_ready;

    ndl_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    ndl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // multiplier operand select per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_CHK0:
            begin
                mul_a = $signed({1'b0, upper_reg ? rl_d : r0_d});
                mul_b = $signed({2'b0, adc_reg});
            end
            ST_CHK1:
            begin
                mul_a = upper_reg ? $signed({2'b0, d256}) : $signed({4'b0, r0});
                mul_b = $signed({5'b0, supply_reg});
            end
            ST_CHK2:
            begin
                mul_a = $signed({1'b0, upper_reg ? r0_d : rl_d});
                mul_b = $signed({2'b0, adc_reg});
            end
            ST_CHK3:
            begin
                mul_a = upper_reg ? $signed({2'b0, d256}) : $signed({4'b0, rl});
                mul_b = $signed({5'b0, supply_reg});
            end
            ST_CHK4:
            begin
                // resistance numerator
                mul_a = $signed({2'b0, d256});
                mul_b = $signed({2'b0, upper_reg ? s_minus_v : adc_reg});
            end
            ST_INT_M0:
            begin
                mul_a = $signed({4'b0, dr});
                mul_b = MUL_B_W'(t0);
            end
            ST_INT_M1:
            begin
                mul_a = $signed({4'b0, off});
                mul_b = MUL_B_W'(dt);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider launch
    always_comb
    begin
        div_ctrl.start      = 1'b0;
        div_ctrl.short_mode = 1'b0;
        div_dividend        = prod[DIVD_W-1:0];
        div_divisor         = DIVS_W'(den16);
        if (state_reg == ST_DIV1 && den16 != 16'd0) begin
            div_ctrl.start = 1'b1;
        end else if (state_reg == ST_INT_SUM) begin
            div_ctrl.start      = 1'b1;
            div_ctrl.short_mode = 1'b1;
            div_dividend        = mag[DIVD_W-1:0];
            div_divisor         = dr;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_CHK0;
            ST_CHK0:      state_next = ST_CHK1;
            ST_CHK1:      state_next = ST_CHK2;
            ST_CHK2:      state_next = ST_CHK3;
            ST_CHK3:      state_next = ST_CHK4;
            ST_CHK4:      state_next = (above_reg || below_now) ? ST_OUT : ST_DIV1;
            ST_DIV1:      state_next = (den16 == 16'd0) ? ST_SEARCH : ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (div_done) state_next = ST_SEARCH;
            ST_SEARCH:    if (lo_reg == hi_reg) state_next = ST_INT_M0;
            ST_INT_M0:    state_next = dr_pos ? ST_INT_M1 : ST_OUT;
            ST_INT_M1:    state_next = ST_INT_SUM;
            ST_INT_SUM:   state_next = ST_DIV2_WAIT;
            ST_DIV2_WAIT: if (div_done) state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // control registers: state, configuration, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            supply_reg    <= 13'd3000;
            divider_reg   <= 20'd10000;
            upper_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SUPPLY:  supply_reg  <= cfg_data[12:0];
                    REG_DIVIDER: divider_reg <= cfg_data;
                    REG_UPPER:   upper_reg   <= cfg_data[0];
                    default:     ;
                endcase
            end
            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                adc_reg <= adc_mv;
            end
            ST_CHK1, ST_CHK3:
            begin
                lhs_reg <= prod;
            end
            ST_CHK2:
            begin
                above_reg <= lhs_reg > prod;
            end
            ST_CHK4:
            begin
                if (above_reg) begin
                    res_temp_reg   <= TEMP_LOW_SENT;
                    res_status_reg <= STATUS_ABOVE;
                end else begin
                    res_temp_reg   <= TEMP_HIGH_SENT;
                    res_status_reg <= STATUS_BELOW;
                end
            end
            ST_DIV1:
            begin
                // zero divisor saturates to the first table resistance
                r_reg  <= r0;
                lo_reg <= '0;
                hi_reg <= SEARCH_HI;
            end
            ST_DIV1_WAIT:
            begin
                if (div_quot > DIVD_W'(r0)) begin
                    r_reg <= r0;
                end else if (div_quot < DIVD_W'(rl)) begin
                    r_reg <= rl;
                end else begin
                    r_reg <= div_quot[RES_W-1:0];
                end
            end
            ST_SEARCH:
            begin
                // lowest index whose next entry is at or below the resistance
                if (lo_reg != hi_reg) begin
                    if (pred) begin
                        hi_reg <= mid;
                    end else begin
                        lo_reg <= mid_p1;
                    end
                end
            end
            ST_INT_M0:
            begin
                res_temp_reg   <= t0;
                res_status_reg <= STATUS_VALID;
            end
            ST_INT_M1:
            begin
                lhs_reg <= prod;
            end
            ST_INT_SUM:
            begin
                neg_reg <= sum_neg;
            end
            ST_DIV2_WAIT:
            begin
                res_temp_reg <= neg_reg ? $signed(-q16) : $signed(q16);
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_OUT && out_free) begin
            out_temp_reg   <= res_temp_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign temp_tenths  = out_temp_reg;
    assign range_status = out_status_reg;

endmodule
